// ===== hdl/mtg_pkg.sv =====
// ============================================================================
// mtg_pkg
// Shared constants, codes and helper functions of the MT19937 generator.
// ============================================================================
package mtg_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned WORDS   = 624;
	localparam int unsigned SHIFT_M = 397;
	localparam int unsigned IDX_W   = $clog2(WORDS);

	localparam logic [WORD_W-1:0] INIT_MUL = 32'd1812433253;
	localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] MATRIX_A = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;

	// Item kind carried on the input tuser
	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_SEED = 1'b1;

	// Last index written by the seed fill
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

	typedef logic [WORD_W-1:0] word_t;

	// Seeder status handed to the top level
	typedef struct packed {
		logic busy;
		word_t word;
	} mtg_seed_ctl_t;

	// One step of the twist recurrence: x[n+624] from x[n], x[n+1], x[n+397]
	function automatic word_t twist_word(word_t w_cur, word_t w_nxt, word_t w_far);
		word_t y;
		word_t w;
		y = (w_cur & UPPER_MASK) | (w_nxt & LOWER_MASK);
		w = w_far ^ (y >> 1);
		if (y[0]) begin
			w = w ^ MATRIX_A;
		end
		return w;
	endfunction

	// Output tempering
	function automatic word_t temper(word_t x);
		word_t y;
		y = x;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== hdl/mersenne_twister_generator.sv =====
// ============================================================================
// mersenne_twister_generator
// MT19937 random word generator built as a 624-cell shift chain.
// ============================================================================
// A seed transfer (tuser = 1, seed in tdata) loads the seed and then fills the
// rest of the state, one word of the init recurrence a cycle through a
// single 32x32 multiplier; s_tready is low while the fill runs and the seed
// gives no output. On a draw transfer (tuser = 0), the twist of
// the next word is computed from cells 0, 1 and 397 of the chain, shifted in
// at the tail, and its tempered value is loaded into the output register.
// Draws sustain one per cycle while m_tready stays high. Draws before the
// first seed return undefined words.
module mersenne_twister_generator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [31:0] seed_value
	input  logic                  s_tuser,   // [0] op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata    // [31:0] random_word
);
	import mtg_pkg::*;

	word_t         cell_out [WORDS];
	word_t         tail_in;
	word_t         new_word;
	logic          in_xfer;
	logic          draw_xfer;
	logic          seed_xfer;
	logic          shift;
	mtg_seed_ctl_t seed_ctl;
	logic          out_valid_q;
	word_t         out_data_q;

	// handshake decode
	assign s_tready  = !seed_ctl.busy && (!out_valid_q || m_tready);
	assign in_xfer   = s_tvalid && s_tready;
	assign draw_xfer = in_xfer && (s_tuser == OP_DRAW);
	assign seed_xfer = in_xfer && (s_tuser == OP_SEED);
	assign shift     = in_xfer || seed_ctl.busy;

	// next word of the sequence
	assign new_word = twist_word(cell_out[0], cell_out[1], cell_out[SHIFT_M]);

	// tail input select
	always_comb begin
		if (seed_xfer) begin
			tail_in = s_tdata;
		end else if (seed_ctl.busy) begin
			tail_in = seed_ctl.word;
		end else begin
			tail_in = new_word;
		end
	end

	// state chain: cell i takes cell i+1, the last cell takes the new word
	for (genvar i = 0; i < WORDS; i++) begin : g_cell
		if (i == WORDS - 1) begin : g_tail
			mtg_cell u_cell (
				.clk  (clk),
				.shift(shift),
				.din  (tail_in),
				.dout (cell_out[i])
			);
		end else begin : g_body
			mtg_cell u_cell (
				.clk  (clk),
				.shift(shift),
				.din  (cell_out[i+1]),
				.dout (cell_out[i])
			);
		end
	end

	mtg_seeder u_seeder (
		.clk   (clk),
		.arst_n(arst_n),
		.start (seed_xfer),
		.tail  (cell_out[WORDS-1]),
		.ctl   (seed_ctl)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_xfer) begin
			out_data_q <= temper(new_word);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hdl/mtg_cell.sv =====
// ============================================================================
// mtg_cell
// One word of the generator state; takes its neighbor's word on each shift.
// ============================================================================
module mtg_cell (
	input  logic               clk,
	input  logic               shift,
	input  mtg_pkg::word_t     din,
	output mtg_pkg::word_t     dout
);
	import mtg_pkg::*;

	word_t word_q;

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= din;
		end
	end

	assign dout = word_q;

endmodule

// ===== hdl/mtg_seeder.sv =====
// ============================================================================
// mtg_seeder
// Seed fill sequencer: produces words 1..623 of the init recurrence.
// ============================================================================
module mtg_seeder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  mtg_pkg::word_t        tail,
	output mtg_pkg::mtg_seed_ctl_t ctl
);
	import mtg_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	word_t            mix;
	word_t            prod;

	// w[i] = MUL * (w[i-1] ^ (w[i-1] >> 30)) + i, w[i-1] sits in the tail cell
	always_comb begin
		mix  = tail ^ (tail >> 30);
		prod = INIT_MUL * mix;
	end

	// fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= IDX_W'(1);
		end else if (busy_q) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign ctl.busy = busy_q;
	assign ctl.word = prod + WORD_W'(idx_q);

endmodule
